@@ rtl/ptt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority timed task table - shared package
// Command and status codes, transaction payloads and the control/status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam logic [31:0] ELAPSED_LIMIT = 32'd1000;

    typedef enum logic [1:0] {
        CMD_SCHEDULE = 2'd0,
        CMD_CANCEL   = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_RESERVED = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_INVALID   = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_FIRED     = 3'd5,
        ST_NONE_DUE  = 3'd6
    } t_status;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] task_id;
        logic [2:0]  priority_req;
        logic [31:0] due_time;
        logic [31:0] interval;
        logic        repeat_req;
        logic        has_handler;
        logic [31:0] tick_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] fired_task_id;
        logic [31:0] now_time;
        logic        last;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic idx_clr;
        logic idx_inc;
        logic prio_inc;
        logic eval;
        logic commit;
        logic fire;
        logic emit_res;
        logic emit_pend_last;
        logic emit_none;
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        t_cmd cmd;
        logic sched_bad;
        logic idx_last;
        logic prio_last;
        logic due_hit;
        logic pend_valid;
        logic out_free;
    } t_dp_stat;

endpackage

@@ rtl/ptt_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority timed task table - channel interfaces
// Valid/ready channels for command transactions and result transactions.
// ----------------------------------------------------------------------------
interface ptt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] task_id;
    logic [2:0]  priority_req;
    logic [31:0] due_time;
    logic [31:0] interval;
    logic        repeat_req;
    logic        has_handler;
    logic [31:0] tick_ms;

    modport source (output valid, command, task_id, priority_req, due_time, interval,
                    repeat_req, has_handler, tick_ms, input ready);
    modport sink   (input valid, command, task_id, priority_req, due_time, interval,
                    repeat_req, has_handler, tick_ms, output ready);
endinterface

interface ptt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] fired_task_id;
    logic [31:0] now_time;
    logic        last;

    modport source (output valid, status, fired_task_id, now_time, last, input ready);
    modport sink   (input valid, status, fired_task_id, now_time, last, output ready);
endinterface

@@ rtl/ptt_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority timed task table - datapath
// Slot memory, valid bits, millisecond clock, scan counters, pending fire
// and result register.
// ----------------------------------------------------------------------------
module ptt_dp #(
    parameter int TASK_SLOTS      = 16,
    parameter int PRIORITY_LEVELS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptt_pkg::t_in_item  i_item,
    input  ptt_pkg::t_ctrl_cmd i_cmd,
    output ptt_pkg::t_dp_stat  o_stat,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output ptt_pkg::t_out_item o_out
);
    import ptt_pkg::*;

    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int PW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;

    typedef struct packed {
        logic [31:0]   id;
        logic [PW-1:0] prio;
        logic [31:0]   due;
        logic [31:0]   ivl;
        logic          rep;
    } t_slot;

    t_slot                 r_mem [TASK_SLOTS];
    t_slot                 r_rd;
    logic [TASK_SLOTS-1:0] r_valid;
    logic [31:0]           r_clock;
    t_cmd                  r_cmd;
    logic [31:0]           r_id;
    logic [PW-1:0]         r_prio;
    logic [31:0]           r_due;
    logic [31:0]           r_ivl;
    logic                  r_rep;
    logic                  r_bad;
    logic [IW-1:0]         r_idx;
    logic [PW-1:0]         r_pcnt;
    logic                  r_dup;
    logic                  r_free_found;
    logic [IW-1:0]         r_free_idx;
    t_status               r_res;
    logic                  r_pend_valid;
    logic [31:0]           r_pend_id;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic        in_bad;
    logic [31:0] el_clamped;
    logic [31:0] due_diff;
    logic        id_hit;
    logic        due_hit;
    logic        out_free;
    logic        rearm;
    logic        commit_ok;
    logic        mem_we;
    logic [IW-1:0] mem_waddr;
    t_slot       mem_wdata;
    logic        out_load;
    t_out_item   n_out;

    always_comb begin
        in_bad = (i_item.task_id == 32'd0) || !i_item.has_handler ||
                 ({29'd0, i_item.priority_req} >= 32'(PRIORITY_LEVELS));
        el_clamped = (i_item.tick_ms > ELAPSED_LIMIT) ? ELAPSED_LIMIT : i_item.tick_ms;
        due_diff   = r_clock - r_rd.due;
        id_hit     = r_valid[r_idx] && (r_rd.id == r_id);
        due_hit    = r_valid[r_idx] && (r_rd.prio == r_pcnt) && !due_diff[31];
        out_free   = !r_out_valid || i_out_ready;
        rearm      = r_rd.rep && (r_rd.ivl != 32'd0);
        commit_ok  = i_cmd.commit && !r_bad && !r_dup && r_free_found;
        mem_we     = commit_ok || (i_cmd.fire && rearm);
        if (i_cmd.commit) begin
            mem_waddr = r_free_idx;
            mem_wdata = '{id: r_id, prio: r_prio, due: r_due, ivl: r_ivl, rep: r_rep};
        end else begin
            mem_waddr = r_idx;
            mem_wdata = r_rd;
            mem_wdata.due = r_rd.due + r_rd.ivl;
        end
    end

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.sched_bad  = r_bad;
        o_stat.idx_last   = (r_idx == IW'(TASK_SLOTS - 1));
        o_stat.prio_last  = (r_pcnt == PW'(PRIORITY_LEVELS - 1));
        o_stat.due_hit    = due_hit;
        o_stat.pend_valid = r_pend_valid;
        o_stat.out_free   = out_free;
    end

    // slot memory: one write port, registered read at the scan index
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (commit_ok) begin
            r_valid[r_free_idx] <= 1'b1;
        end else if (i_cmd.eval && r_cmd == CMD_CANCEL && id_hit) begin
            r_valid[r_idx] <= 1'b0;
        end else if (i_cmd.fire && !rearm) begin
            r_valid[r_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock <= '0;
        end else if (i_cmd.capture && t_cmd'(i_item.command) == CMD_TICK) begin
            r_clock <= r_clock + el_clamped;
        end
    end

    // captured command fields and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd        <= CMD_RESERVED;
            r_idx        <= '0;
            r_pcnt       <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_cmd  <= t_cmd'(i_item.command);
                r_id   <= (t_cmd'(i_item.command) == CMD_RESERVED) ? 32'd0 : i_item.task_id;
                r_prio <= i_item.priority_req[PW-1:0];
                r_due  <= i_item.due_time;
                r_ivl  <= i_item.interval;
                r_rep  <= i_item.repeat_req;
                r_bad  <= in_bad;
                r_dup        <= 1'b0;
                r_free_found <= 1'b0;
                r_pcnt       <= '0;
                unique case (t_cmd'(i_item.command))
                    CMD_SCHEDULE: begin
                        if (in_bad) begin
                            r_res <= ST_INVALID;
                        end else begin
                            r_res <= ST_FULL;
                        end
                    end
                    CMD_CANCEL:   r_res <= ST_NOT_FOUND;
                    CMD_TICK:     r_res <= ST_NONE_DUE;
                    default:      r_res <= ST_INVALID;
                endcase
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.prio_inc) begin
                r_pcnt <= r_pcnt + 1'b1;
            end
            if (i_cmd.eval && r_cmd == CMD_SCHEDULE && !r_bad) begin
                if (id_hit) begin
                    r_dup <= 1'b1;
                    r_res <= ST_DUPLICATE;
                end
                if (!r_valid[r_idx] && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_idx;
                end
            end
            if (i_cmd.eval && r_cmd == CMD_CANCEL && id_hit) begin
                r_res <= ST_ACCEPTED;
            end
            if (commit_ok) begin
                r_res <= ST_ACCEPTED;
            end
            if (i_cmd.fire) begin
                r_pend_valid <= 1'b1;
                r_pend_id    <= r_rd.id;
            end else if (i_cmd.emit_pend_last) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // result register
    always_comb begin
        out_load = (i_cmd.fire && r_pend_valid) || i_cmd.emit_res ||
                   i_cmd.emit_pend_last || i_cmd.emit_none;
        n_out.now_time = r_clock;
        if (i_cmd.emit_res) begin
            n_out.status        = r_res;
            n_out.fired_task_id = r_id;
            n_out.last          = 1'b1;
        end else if (i_cmd.emit_none) begin
            n_out.status        = ST_NONE_DUE;
            n_out.fired_task_id = 32'd0;
            n_out.last          = 1'b1;
        end else begin
            n_out.status        = ST_FIRED;
            n_out.fired_task_id = r_pend_id;
            n_out.last          = i_cmd.emit_pend_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result register overwritten before transaction");

    a_clock_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.capture && t_cmd'(i_item.command) == CMD_TICK) |=> $stable(r_clock))
        else $error("clock moved without a tick");

    a_fired_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_FIRED) |-> (r_out.fired_task_id != 32'd0))
        else $error("fired task with zero id");

endmodule

@@ rtl/ptt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority timed task table - controller
// Sequences the slot scan for schedule, cancel and tick transactions.
// ----------------------------------------------------------------------------
module ptt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ptt_pkg::t_dp_stat  i_stat,
    output ptt_pkg::t_ctrl_cmd o_cmd
);
    import ptt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_EVAL   = 6'b000100,
        S_COMMIT = 6'b001000,
        S_FINISH = 6'b010000,
        S_TFIN   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                if (i_stat.cmd == CMD_RESERVED ||
                    (i_stat.cmd == CMD_SCHEDULE && i_stat.sched_bad)) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                case (i_stat.cmd) inside
                    CMD_SCHEDULE, CMD_CANCEL: begin
                        o_cmd.eval = 1'b1;
                        if (i_stat.idx_last) begin
                            n_state = (i_stat.cmd == CMD_SCHEDULE) ? S_COMMIT : S_FINISH;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                            n_state       = S_READ;
                        end
                    end
                    CMD_TICK: begin
                        // hold while the previous fire cannot be pushed out
                        if (!(i_stat.due_hit && i_stat.pend_valid && !i_stat.out_free)) begin
                            o_cmd.fire = i_stat.due_hit;
                            n_state    = S_READ;
                            if (!i_stat.idx_last) begin
                                o_cmd.idx_inc = 1'b1;
                            end else if (i_stat.prio_last) begin
                                n_state = S_TFIN;
                            end else begin
                                o_cmd.prio_inc = 1'b1;
                                o_cmd.idx_clr  = 1'b1;
                            end
                        end
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_res = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_TFIN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_pend_last = i_stat.pend_valid;
                    o_cmd.emit_none      = !i_stat.pend_valid;
                    n_state              = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/priority_timed_task_table.sv @@
`timescale 1ns / 1ps
// Cancel scans every slot, schedule scans every slot then enters the commit state, a rejected
// schedule or unused command skips the scan, and tick scans every slot once per priority level;
// each slot visit is a memory read state then an evaluate state.
// One transaction at a time: the next is accepted in the cycle after the final result
// is loaded; a full output holds the scan at a second fire and holds the final result.
// Reset: valid bits and clock cleared at once; slot memory is not cleared.
// ----------------------------------------------------------------------------
// Priority timed task table - top level
// Timed task table with priority-ordered firing on each tick.
// ----------------------------------------------------------------------------
module priority_timed_task_table #(
    parameter int TASK_SLOTS      = 16,
    parameter int PRIORITY_LEVELS = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ptt_in_if.sink    i_in,
    ptt_out_if.source o_out
);
    import ptt_pkg::*;

    t_in_item  item;
    t_ctrl_cmd cmd;
    t_dp_stat  stat;
    t_out_item res;
    logic      in_ready;
    logic      res_valid;

    always_comb begin
        item.command      = i_in.command;
        item.task_id      = i_in.task_id;
        item.priority_req = i_in.priority_req;
        item.due_time     = i_in.due_time;
        item.interval     = i_in.interval;
        item.repeat_req   = i_in.repeat_req;
        item.has_handler  = i_in.has_handler;
        item.tick_ms      = i_in.tick_ms;
    end

    ptt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ptt_dp #(
        .TASK_SLOTS      (TASK_SLOTS),
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (o_out.ready),
        .o_out_valid (res_valid),
        .o_out       (res)
    );

    assign i_in.ready          = in_ready;
    assign o_out.valid         = res_valid;
    assign o_out.status        = res.status;
    assign o_out.fired_task_id = res.fired_task_id;
    assign o_out.now_time      = res.now_time;
    assign o_out.last          = res.last;

endmodule
